FILE: src/esbp_pkg.sv
// package for the exact-size block pool: widths, payload structs, op codes, states
// used by every module of the block

package esbp_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int STAT_DEPTH = 16;
    localparam int PIDX_W = $clog2(POOL_DEPTH);
    localparam int SIDX_W = $clog2(STAT_DEPTH);
    localparam int AGE_W = $clog2(POOL_DEPTH);
    localparam int HANDLE_W = 48;
    localparam int SIZE_W = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DRAIN   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic [SIZE_W-1:0]   size_bytes;
        logic [HANDLE_W-1:0] handle_in;
        logic                free_to_device;
    } in_item_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle_out;
        logic                handle_valid;
        logic [COUNT_W-1:0]  serve_count;
        logic                pool_full;
        logic                stats_full;
        logic                last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item and match vectors
        logic exec;       // perform acquire / release / simple result
        logic drain_step; // emit the current drain handle
        logic drain_clear;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_drain;
        logic is_drain_emit;
        logic drain_last;
    } stat_t;

endpackage

FILE: src/esbp_datapath.sv
// datapath of the exact-size block pool: pool and count tables, tag compare, result register
// depends on esbp_pkg

module esbp_datapath
    import esbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item_in,
    input  ctrl_t     ctrl,
    output stat_t     status,
    output out_item_t result
);

    logic [HANDLE_W-1:0] entry_handle_reg [POOL_DEPTH];
    logic [SIZE_W-1:0]   entry_size_reg [POOL_DEPTH];
    logic [AGE_W-1:0]    entry_age_reg [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] entry_valid_reg;
    logic [SIZE_W-1:0]   stat_size_reg [STAT_DEPTH];
    logic [COUNT_W-1:0]  stat_count_reg [STAT_DEPTH];
    logic [STAT_DEPTH-1:0] stat_valid_reg;

    in_item_t item_reg;
    logic [POOL_DEPTH-1:0] pmatch_reg;
    logic [STAT_DEPTH-1:0] smatch_reg;
    logic [AGE_W:0] drain_age_reg;
    logic [AGE_W:0] total_reg;
    out_item_t result_reg;
    out_item_t result_next;

    // first stage: parallel tag compare against the incoming item
    logic [POOL_DEPTH-1:0] pmatch_next;
    logic [STAT_DEPTH-1:0] smatch_next;
    always_comb
    begin
        for (int i = 0; i < POOL_DEPTH; i++)
            pmatch_next[i] = entry_valid_reg[i] && entry_size_reg[i] == item_in.size_bytes;
        for (int i = 0; i < STAT_DEPTH; i++)
            smatch_next[i] = stat_valid_reg[i] && stat_size_reg[i] == item_in.size_bytes;
    end

    // second stage: selections from the registered match vectors
    logic              best_found;
    logic [PIDX_W-1:0] best_idx;
    logic [AGE_W-1:0]  best_age;
    logic              s_found;
    logic [SIDX_W-1:0] s_idx;
    logic              s_free_found;
    logic [SIDX_W-1:0] s_free_idx;
    logic              p_free_found;
    logic [PIDX_W-1:0] p_free_idx;
    logic [AGE_W:0]    valid_cnt;
    logic [PIDX_W-1:0] drain_idx;
    always_comb
    begin
        best_found = 1'b0;
        best_idx = '0;
        best_age = '0;
        s_found = 1'b0;
        s_idx = '0;
        s_free_found = 1'b0;
        s_free_idx = '0;
        p_free_found = 1'b0;
        p_free_idx = '0;
        valid_cnt = '0;
        drain_idx = '0;
        // ages of valid entries are distinct, so the lowest matching age is a one-hot pick
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            if (pmatch_reg[i] && (!best_found || entry_age_reg[i] < best_age))
            begin
                best_found = 1'b1;
                best_idx = PIDX_W'(i);
                best_age = entry_age_reg[i];
            end
            if (!entry_valid_reg[i] && !p_free_found)
            begin
                p_free_found = 1'b1;
                p_free_idx = PIDX_W'(i);
            end
            valid_cnt = valid_cnt + (AGE_W+1)'(entry_valid_reg[i]);
            if (entry_valid_reg[i] && {1'b0, entry_age_reg[i]} == drain_age_reg)
                drain_idx = PIDX_W'(i);
        end
        for (int i = 0; i < STAT_DEPTH; i++)
        begin
            if (smatch_reg[i])
            begin
                s_found = 1'b1;
                s_idx = SIDX_W'(i);
            end
            if (!stat_valid_reg[i] && !s_free_found)
            begin
                s_free_found = 1'b1;
                s_free_idx = SIDX_W'(i);
            end
        end
    end

    logic              s_ok;
    logic [SIDX_W-1:0] s_use;
    logic [COUNT_W-1:0] s_cur;
    logic [COUNT_W-1:0] s_inc;
    assign s_ok  = s_found || s_free_found;
    assign s_use = s_found ? s_idx : s_free_idx;
    assign s_cur = s_found ? stat_count_reg[s_idx] : '0;
    assign s_inc = (s_cur == COUNT_MAX) ? s_cur : s_cur + COUNT_W'(1);

    assign status.is_drain = item_reg.operation == OP_DRAIN;
    assign status.is_drain_emit = item_reg.operation == OP_DRAIN && item_reg.free_to_device
                                  && total_reg != '0;
    assign status.drain_last = drain_age_reg + (AGE_W+1)'(1) == total_reg;

    always_comb
    begin
        result_next = '0;
        result_next.last = 1'b1;
        if (ctrl.drain_step)
        begin
            result_next.handle_out = entry_handle_reg[drain_idx];
            result_next.handle_valid = 1'b1;
            result_next.last = status.drain_last;
        end
        else if (item_reg.operation == OP_ACQUIRE)
        begin
            result_next.hit = best_found;
            result_next.handle_valid = best_found;
            result_next.handle_out = best_found ? entry_handle_reg[best_idx] : '0;
            result_next.serve_count = !s_ok ? '0 : (best_found ? s_inc : s_cur);
            result_next.stats_full = !s_ok;
        end
        else if (item_reg.operation == OP_RELEASE)
            result_next.pool_full = !p_free_found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            stat_valid_reg <= '0;
            for (int i = 0; i < POOL_DEPTH; i++)
                entry_age_reg[i] <= '0;
            for (int i = 0; i < STAT_DEPTH; i++)
                stat_count_reg[i] <= '0;
            drain_age_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                drain_age_reg <= '0;
                total_reg <= valid_cnt;
            end
            if (ctrl.exec)
            begin
                unique case (op_t'(item_reg.operation))
                    OP_ACQUIRE:
                    begin
                        if (!s_found && s_free_found)
                            stat_valid_reg[s_free_idx] <= 1'b1;
                        if (s_ok)
                            stat_count_reg[s_use] <= best_found ? s_inc : s_cur;
                        if (best_found)
                        begin
                            entry_valid_reg[best_idx] <= 1'b0;
                            for (int i = 0; i < POOL_DEPTH; i++)
                                if (entry_valid_reg[i] && entry_age_reg[i] > best_age)
                                    entry_age_reg[i] <= entry_age_reg[i] - AGE_W'(1);
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (p_free_found)
                        begin
                            for (int i = 0; i < POOL_DEPTH; i++)
                                if (entry_valid_reg[i])
                                    entry_age_reg[i] <= entry_age_reg[i] + AGE_W'(1);
                            entry_valid_reg[p_free_idx] <= 1'b1;
                            entry_age_reg[p_free_idx] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctrl.drain_step)
                drain_age_reg <= drain_age_reg + (AGE_W+1)'(1);
            if (ctrl.drain_clear)
            begin
                entry_valid_reg <= '0;
                stat_valid_reg <= '0;
                for (int i = 0; i < STAT_DEPTH; i++)
                    stat_count_reg[i] <= '0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            item_reg <= item_in;
            pmatch_reg <= pmatch_next;
            smatch_reg <= smatch_next;
        end
        if (ctrl.exec && item_reg.operation == OP_RELEASE && p_free_found)
        begin
            entry_handle_reg[p_free_idx] <= item_reg.handle_in;
            entry_size_reg[p_free_idx] <= item_reg.size_bytes;
        end
        if (ctrl.exec && item_reg.operation == OP_ACQUIRE && !s_found && s_free_found)
            stat_size_reg[s_free_idx] <= item_reg.size_bytes;
        if (ctrl.exec || ctrl.drain_step)
            result_reg <= result_next;
    end

    assign result = result_reg;

    a_ages_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.drain_step |-> drain_age_reg < total_reg)
        else $error("drain walked past the pooled entries");
    a_release_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.exec && item_reg.operation == OP_RELEASE && p_free_found)
        |=> entry_valid_reg != '0)
        else $error("release left the pool empty");
    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.drain_clear |=> entry_valid_reg == '0 && stat_valid_reg == '0)
        else $error("drain did not clear the tables");

endmodule

FILE: src/esbp_ctrl.sv
// controller of the exact-size block pool: sequences load, execute, drain and output
// depends on esbp_pkg

module esbp_ctrl
    import esbp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t status,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic is_drain_reg, is_drain_next;

    // remember whether the result held in the output register was the final one
    logic result_last_seen;
    logic last_reg;
    assign result_last_seen = last_reg;

    logic out_fire;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        is_drain_next = is_drain_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (status.is_drain_emit)
                    state_next = ST_DRAIN;
                else
                    state_next = ST_OUT;
            ST_DRAIN:
                state_next = ST_OUT;
            ST_OUT:
                if (out_fire)
                begin
                    if (is_drain_reg && !result_last_seen)
                        state_next = ST_DRAIN;
                    else
                        state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
        if (state_reg == ST_EXEC)
            is_drain_next = status.is_drain_emit;
    end

    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.load = in_valid;
            end
            ST_EXEC:
            begin
                ctrl.exec = !status.is_drain_emit;
                ctrl.drain_clear = !status.is_drain_emit && status.is_drain;
            end
            ST_DRAIN:
            begin
                ctrl.drain_step = 1'b1;
                ctrl.drain_clear = status.drain_last;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            is_drain_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            is_drain_reg <= is_drain_next;
            if (ctrl.drain_step)
                last_reg <= status.drain_last;
        end
    end

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");
    a_drain_step_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.drain_step |=> out_valid)
        else $error("drain step not presented");
    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && in_valid) |=> state_reg == ST_EXEC)
        else $error("accepted item not executed");

endmodule

FILE: src/exact_size_block_pool_unit.sv
// Exact-size block pool. An accepted item goes through tag compare, then table update into
// the output register, where its result is presented; an emitting drain presents its handles
// one at a time while the receiver takes them. The next item is accepted in the cycle after
// the last result of the previous one is taken, so the unit holds only one item at a time.
// depends on esbp_pkg, esbp_ctrl, esbp_datapath

module exact_size_block_pool_unit
    import esbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    ctrl_t ctrl;
    stat_t status;

    esbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    esbp_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (in_data),
        .ctrl    (ctrl),
        .status  (status),
        .result  (out_data)
    );

endmodule

FILE: sim/tb_exact_size_block_pool_unit.sv
// testbench for exact_size_block_pool_unit: directed table, counter-table fill, random items,
// each result checked against the pool model or a typed-in want; depends on esbp_pkg
`timescale 1ns / 100ps

module tb_exact_size_block_pool_unit;
    import esbp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM = 266;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    exact_size_block_pool_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // pool model
    logic [HANDLE_W-1:0] pool_handle [POOL_DEPTH];
    logic [SIZE_W-1:0]   pool_size [POOL_DEPTH];
    bit                  pool_used [POOL_DEPTH];
    int unsigned         pool_age [POOL_DEPTH];
    logic [SIZE_W-1:0]   cnt_size [STAT_DEPTH];
    logic [COUNT_W-1:0]  cnt_val [STAT_DEPTH];
    bit                  cnt_used [STAT_DEPTH];

    out_item_t pending_results[$];
    int        errors;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        long_hold;

    // recently released sizes, so acquires hit
    logic [SIZE_W-1:0] recent_sizes[$];

    task automatic report_mismatch(input string what, input out_item_t got,
                                   input out_item_t want);
        $display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
        errors++;
    endtask

    function automatic out_item_t blank_result();
        out_item_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_pool(input in_item_t it);
        out_item_t r;
        int s;
        int best;
        int slot;
        int total;
        int n;
        int unsigned a;
        r = blank_result();
        case (it.operation)
            OP_ACQUIRE:
            begin
                s = -1;
                for (int i = 0; i < STAT_DEPTH; i++)
                    if (cnt_used[i] && cnt_size[i] == it.size_bytes && s < 0)
                        s = i;
                if (s < 0)
                begin
                    for (int i = 0; i < STAT_DEPTH; i++)
                        if (!cnt_used[i] && s < 0)
                            s = i;
                    if (s >= 0)
                    begin
                        cnt_used[s] = 1;
                        cnt_size[s] = it.size_bytes;
                        cnt_val[s] = '0;
                    end
                end
                best = -1;
                for (int i = 0; i < POOL_DEPTH; i++)
                    if (pool_used[i] && pool_size[i] == it.size_bytes &&
                        (best < 0 || pool_age[i] < pool_age[best]))
                        best = i;
                r.stats_full = (s < 0);
                if (best < 0)
                    r.serve_count = (s >= 0) ? cnt_val[s] : '0;
                else
                begin
                    a = pool_age[best];
                    pool_used[best] = 0;
                    for (int i = 0; i < POOL_DEPTH; i++)
                        if (pool_used[i] && pool_age[i] > a)
                            pool_age[i]--;
                    if (s >= 0)
                    begin
                        if (cnt_val[s] != COUNT_MAX)
                            cnt_val[s]++;
                        r.serve_count = cnt_val[s];
                    end
                    r.hit = 1;
                    r.handle_out = pool_handle[best];
                    r.handle_valid = 1;
                end
                pending_results.push_back(r);
            end
            OP_RELEASE:
            begin
                slot = -1;
                for (int i = 0; i < POOL_DEPTH; i++)
                    if (!pool_used[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                    r.pool_full = 1;
                else
                begin
                    for (int i = 0; i < POOL_DEPTH; i++)
                        if (pool_used[i])
                            pool_age[i]++;
                    pool_used[slot] = 1;
                    pool_handle[slot] = it.handle_in;
                    pool_size[slot] = it.size_bytes;
                    pool_age[slot] = 0;
                end
                pending_results.push_back(r);
            end
            OP_DRAIN:
            begin
                n = 0;
                if (it.free_to_device)
                begin
                    total = 0;
                    for (int i = 0; i < POOL_DEPTH; i++)
                        if (pool_used[i])
                            total++;
                    for (int k = 0; k < total; k++)
                        for (int i = 0; i < POOL_DEPTH; i++)
                            if (pool_used[i] && pool_age[i] == k)
                            begin
                                r = '0;
                                r.handle_out = pool_handle[i];
                                r.handle_valid = 1;
                                r.last = (k == total - 1);
                                pending_results.push_back(r);
                                n++;
                            end
                end
                for (int i = 0; i < POOL_DEPTH; i++)
                    pool_used[i] = 0;
                for (int i = 0; i < STAT_DEPTH; i++)
                begin
                    cnt_used[i] = 0;
                    cnt_val[i] = '0;
                end
                if (n == 0)
                    pending_results.push_back(blank_result());
            end
            default:
                pending_results.push_back(r);
        endcase
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("** exact_size_block_pool_unit: FAILED **");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", out_data, '0);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.hit != want.hit)
                    report_mismatch("hit", out_data, want);
                if (out_data.handle_out != want.handle_out)
                    report_mismatch("handle_out", out_data, want);
                if (out_data.handle_valid != want.handle_valid)
                    report_mismatch("handle_valid", out_data, want);
                if (out_data.serve_count != want.serve_count)
                    report_mismatch("serve_count", out_data, want);
                if (out_data.pool_full != want.pool_full)
                    report_mismatch("pool_full", out_data, want);
                if (out_data.stats_full != want.stats_full)
                    report_mismatch("stats_full", out_data, want);
                if (out_data.last != want.last)
                    report_mismatch("last", out_data, want);
            end
        end
    end

    // receiver stalls
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 0;
                repeat (120) @(negedge clk);
                long_hold = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // table rows: item plus optional typed-in expectation
    typedef struct {
        in_item_t  item;
        bit        has_want;
        out_item_t want;
    } row_t;

    // called at a falling edge; returns at a falling edge after valid has dropped
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        // ready only changes at rising edges, so its value here holds for the next edge
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        predict_pool(it);
        if (it.operation == OP_RELEASE)
        begin
            recent_sizes.push_back(it.size_bytes);
            if (recent_sizes.size() > 8)
                void'(recent_sizes.pop_front());
        end
        @(negedge clk);
        in_valid <= 0;
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(input logic [1:0] op, input logic [SIZE_W-1:0] sz,
                                           input logic [HANDLE_W-1:0] h, input logic f);
        in_item_t it;
        it.operation = op;
        it.size_bytes = sz;
        it.handle_in = h;
        it.free_to_device = f;
        return it;
    endfunction

    function automatic logic [HANDLE_W-1:0] rand_handle();
        return HANDLE_W'({$urandom(), $urandom()});
    endfunction

    task automatic wait_empty();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        row_t rows[$];
        row_t r;
        in_item_t it;
        int pick;
        logic [SIZE_W-1:0] sz;

        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 0;
        in_valid = 0;
        in_data = '0;
        for (int i = 0; i < POOL_DEPTH; i++)
            pool_used[i] = 0;
        for (int i = 0; i < STAT_DEPTH; i++)
        begin
            cnt_used[i] = 0;
            cnt_val[i] = '0;
        end
        rst_n = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed table
        r.has_want = 1;
        r.item = make_item(OP_ACQUIRE, '0, '0, 1'b0);
        r.want = blank_result();
        rows.push_back(r);
        r.item = make_item(OP_DRAIN, '1, '1, 1'b1);
        rows.push_back(r);
        r.item = make_item(OP_NONE, '1, '1, 1'b1);
        rows.push_back(r);
        r.has_want = 0;
        r.item = make_item(OP_RELEASE, '1, '1, 1'b0);
        rows.push_back(r);
        r.item = make_item(OP_RELEASE, '1, 48'h1234_5678_9abc, 1'b1);
        rows.push_back(r);
        r.item = make_item(OP_ACQUIRE, '1, '0, 1'b1);
        rows.push_back(r);
        for (int i = 0; i < 17; i++)
        begin
            r.item = make_item(OP_RELEASE, i % 3, 48'h100 + i, 1'b0);
            rows.push_back(r);
        end
        r.item = make_item(OP_DRAIN, '0, '0, 1'b1);
        rows.push_back(r);
        r.item = make_item(OP_DRAIN, '0, '0, 1'b0);
        rows.push_back(r);
        foreach (rows[i])
        begin
            send_item(rows[i].item);
            if (rows[i].has_want)
            begin
                // replace predicted entry with the typed-in one
                void'(pending_results.pop_back());
                pending_results.push_back(rows[i].want);
            end
        end
        wait_empty();
        // fill counter table past its depth
        for (int i = 0; i < STAT_DEPTH + 2; i++)
            send_item(make_item(OP_ACQUIRE, 32'h1000 + i, '0, 1'b0));
        send_item(make_item(OP_DRAIN, '0, '0, 1'b0));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            case ((n * 5) / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (n == 100)
                long_hold = 1;
            if (n == 150)
                wait_empty();
            pick = $urandom_range(99);
            if (recent_sizes.size() != 0 && $urandom_range(2) != 0)
                sz = recent_sizes[$urandom_range(recent_sizes.size() - 1)];
            else if ($urandom_range(3) == 0)
                sz = $urandom();
            else
                sz = $urandom_range(7);
            if (pick < 45)
                it = make_item(OP_RELEASE, sz, rand_handle(), 1'($urandom_range(1)));
            else if (pick < 90)
                it = make_item(OP_ACQUIRE, sz, rand_handle(), 1'($urandom_range(1)));
            else if (pick < 97)
                it = make_item(OP_DRAIN, sz, rand_handle(), $urandom_range(3) != 0);
            else
                it = make_item(OP_NONE, sz, rand_handle(), 1'($urandom_range(1)));
            send_item(it);
        end
        recv_stall_pct = 0;
        wait_empty();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("** exact_size_block_pool_unit: PASSED **");
        else
            $display("** exact_size_block_pool_unit: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/esbp_pkg.sv
src/esbp_datapath.sv
src/esbp_ctrl.sv
src/exact_size_block_pool_unit.sv
sim/tb_exact_size_block_pool_unit.sv
